### rtl/crtk_pkg.sv
// Shared types and constants for the constrained residual best-K list.
// Used by every module of the block; depends on nothing.
package crtk_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int LIST_DEPTH = 64;
  localparam int IDX_W      = $clog2(LIST_DEPTH);
  localparam int FRAC_W     = FRAC_BITS + 1;
  localparam int RECIP_W    = FRAC_BITS;
  localparam int CNT_W      = 20;
  localparam int RANK_W     = 6;
  localparam int SCORE_W    = 54;

  localparam int ONE_Q  = 1 << FRAC_BITS;
  localparam int LIM_LO = (2 * ONE_Q + 50) / 100;
  localparam int LIM_HI = (98 * ONE_Q + 50) / 100;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;
  localparam int REG_W  = 3;

  localparam logic [REG_W-1:0] REG_N_OUT0         = 3'd0;
  localparam logic [REG_W-1:0] REG_N_OUT1         = 3'd1;
  localparam logic [REG_W-1:0] REG_N_OUT2         = 3'd2;
  localparam logic [REG_W-1:0] REG_LAMBDA_START   = 3'd3;
  localparam logic [REG_W-1:0] REG_MW_RATIO_RECIP = 3'd4;

  localparam logic [RECIP_W-1:0] RECIP_RESET = RECIP_W'(16384);

  typedef enum logic {
    OP_SCORE = 1'b0,
    OP_READ  = 1'b1
  } op_t;

  typedef struct packed {
    op_t               operation;
    logic [FRAC_W-1:0] beta_first;
    logic [FRAC_W-1:0] mortality_first;
    logic [FRAC_W-1:0] beta_second;
    logic [RANK_W-1:0] read_rank;
  } req_t;

  typedef struct packed {
    logic               accepted;
    logic [RANK_W-1:0]  insert_rank;
    logic               entry_valid;
    logic [FRAC_W-1:0]  entry_beta_first;
    logic [FRAC_W-1:0]  entry_mortality_first;
    logic [FRAC_W-1:0]  entry_beta_second;
    logic [FRAC_W-1:0]  entry_mortality_second;
    logic [SCORE_W-1:0] entry_score;
  } rsp_t;

  typedef struct packed {
    logic [CNT_W-1:0]   n_out0;
    logic [CNT_W-1:0]   n_out1;
    logic [CNT_W-1:0]   n_out2;
    logic [FRAC_W-1:0]  lambda_start;
    logic [RECIP_W-1:0] mw_ratio_recip;
  } cfg_t;

  // classified word handed from the scoring front to the list
  typedef struct packed {
    op_t                op;
    logic               pass;
    logic [RANK_W-1:0]  rank;
    logic [FRAC_W-1:0]  b0;
    logic [FRAC_W-1:0]  m0;
    logic [FRAC_W-1:0]  b1;
    logic [FRAC_W-1:0]  m1;
    logic [SCORE_W-1:0] score;
  } word_t;

endpackage

### rtl/crtk_front.sv
// Scoring front: six-stage pipeline that forms mw1, checks the constraints
// and computes the residual score. Depends on crtk_pkg.
module crtk_front (
  input  logic            clk,
  input  logic            rst,
  input  crtk_pkg::cfg_t  cfg,
  input  logic            req_valid,
  output logic            req_ready,
  input  crtk_pkg::req_t  req,
  output logic            word_valid,
  input  logic            word_full,
  output crtk_pkg::word_t word
);

  localparam int SW    = crtk_pkg::FRAC_W + 3;
  localparam int PM_W  = crtk_pkg::FRAC_W + crtk_pkg::RECIP_W;
  localparam int P_W   = crtk_pkg::CNT_W + crtk_pkg::FRAC_W;
  localparam int T_W   = P_W + crtk_pkg::FRAC_W;
  localparam int SUM_W = T_W + 1;
  localparam int FB    = crtk_pkg::FRAC_BITS;
  localparam int FW    = crtk_pkg::FRAC_W;

  localparam logic signed [SW-1:0] LO_S  = SW'(crtk_pkg::LIM_LO);
  localparam logic signed [SW-1:0] HI_S  = SW'(crtk_pkg::LIM_HI);
  localparam logic signed [SW-1:0] ONE_S = SW'(crtk_pkg::ONE_Q);
  localparam logic [PM_W-1:0]      HALF  = PM_W'(1) << (FB - 1);
  localparam logic [SUM_W-1:0]     SMAX  = SUM_W'({crtk_pkg::SCORE_W{1'b1}});

  logic adv;
  logic v1, v2, v3, v4, v5, v6;

  // stage 1
  crtk_pkg::op_t            op1;
  logic [crtk_pkg::RANK_W-1:0] rank1;
  logic [FW-1:0]            b0_1, m0_1, b1_1;
  logic [PM_W-1:0]          pm1;
  logic [P_W-1:0]           p01_1, p2_1, p3_1;

  // stage 2
  crtk_pkg::word_t          wd2;
  logic                     mpok2, bok2;
  logic signed [SW-1:0]     omb1_2;
  logic [P_W-1:0]           p01_2, p2_2, p3_2;

  // stage 3
  crtk_pkg::word_t          wd3;
  logic [FW-1:0]            lam1_3;
  logic [P_W-1:0]           p01_3, p2_3, p3_3;

  // stage 4
  crtk_pkg::word_t          wd4;
  logic [T_W-1:0]           t1_4;
  logic [P_W-1:0]           t4_4, p2_4, p3_4;

  // stage 5
  crtk_pkg::word_t          wd5;
  logic [T_W-1:0]           d1_5;
  logic [P_W-1:0]           d2_5;

  // stage 6
  crtk_pkg::word_t          w6;

  logic [FW-1:0]            m1_c;
  logic signed [SW-1:0]     mp_c, lam1_c;
  logic                     lam_ok;
  logic [T_W-1:0]           t2_c;
  logic [SUM_W-1:0]         sum_c;
  crtk_pkg::word_t          wd3_c, w6_c;

  assign adv        = !v6 || !word_full;
  assign req_ready  = adv;
  assign word_valid = v6;
  assign word       = w6;

  always_comb begin
    m1_c   = FW'((pm1 + HALF) >> FB);
    mp_c   = ONE_S - $signed(SW'(b0_1)) - $signed(SW'(cfg.lambda_start))
             - $signed(SW'(m0_1));
    lam1_c = omb1_2 - $signed(SW'(wd2.m1));
    lam_ok = (lam1_c >= LO_S) && (lam1_c <= HI_S)
             && (lam1_c > $signed(SW'(cfg.lambda_start)) + LO_S);
    t2_c   = T_W'({p2_4, {FB{1'b0}}});
    sum_c  = SUM_W'(d1_5) + SUM_W'({d2_5, {FB{1'b0}}});

    wd3_c      = wd2;
    wd3_c.pass = mpok2 && bok2 && lam_ok;
    w6_c       = wd5;
    w6_c.score = (sum_c > SMAX) ? {crtk_pkg::SCORE_W{1'b1}}
                                : sum_c[crtk_pkg::SCORE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (adv) begin
      v1 <= req_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op1   <= req.operation;
      rank1 <= req.read_rank;
      b0_1  <= req.beta_first;
      m0_1  <= req.mortality_first;
      b1_1  <= req.beta_second;
      pm1   <= PM_W'(req.mortality_first * cfg.mw_ratio_recip);
      p01_1 <= P_W'(cfg.n_out0 * req.beta_first);
      p2_1  <= P_W'(cfg.n_out1 * cfg.lambda_start);
      p3_1  <= P_W'(cfg.n_out1 * req.beta_second);

      wd2.op    <= op1;
      wd2.pass  <= 1'b0;
      wd2.rank  <= rank1;
      wd2.b0    <= b0_1;
      wd2.m0    <= m0_1;
      wd2.b1    <= b1_1;
      wd2.m1    <= m1_c;
      wd2.score <= '0;
      mpok2     <= (mp_c >= LO_S) && (mp_c <= HI_S);
      bok2      <= $signed(SW'(b1_1)) > $signed(SW'(b0_1)) + LO_S;
      omb1_2    <= ONE_S - $signed(SW'(b1_1));
      p01_2     <= p01_1;
      p2_2      <= p2_1;
      p3_2      <= p3_1;

      wd3      <= wd3_c;
      lam1_3   <= lam1_c[FW-1:0];
      p01_3    <= p01_2;
      p2_3     <= p2_2;
      p3_3     <= p3_2;

      wd4  <= wd3;
      t1_4 <= T_W'(p01_3 * lam1_3);
      t4_4 <= P_W'(cfg.n_out2 * lam1_3);
      p2_4 <= p2_3;
      p3_4 <= p3_3;

      wd5  <= wd4;
      d1_5 <= (t1_4 > t2_c) ? t1_4 - t2_c : t2_c - t1_4;
      d2_5 <= (p3_4 > t4_4) ? p3_4 - t4_4 : t4_4 - p3_4;

      w6 <= w6_c;
    end
  end

endmodule

### rtl/crtk_queue.sv
// Short FIFO of classified words between the scoring front and the list.
// Depends on crtk_pkg.
module crtk_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            full,
  input  crtk_pkg::word_t push_word,
  input  logic            pop,
  output logic            head_valid,
  output crtk_pkg::word_t head_word
);

  crtk_pkg::word_t slots [crtk_pkg::QDEPTH];
  logic [crtk_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [crtk_pkg::QPTR_W:0]   count;
  logic push;

  assign full       = count == (crtk_pkg::QPTR_W + 1)'(crtk_pkg::QDEPTH);
  assign head_valid = count != '0;
  assign head_word  = slots[rd_ptr];
  assign push       = push_valid && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_word;
    end
  end

endmodule

### rtl/crtk_list.sv
// Best-K list: row of compare-and-shift slots with a sequencer for insert
// and read-by-rank words. Depends on crtk_pkg.
module crtk_list (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  crtk_pkg::word_t head_word,
  output logic            pop,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output crtk_pkg::rsp_t  rsp
);

  localparam int LD     = crtk_pkg::LIST_DEPTH;
  localparam int GROUP  = 8;
  localparam int LOW_W  = $clog2(GROUP);
  localparam int N_GRP  = LD / GROUP;
  localparam int GSEL_W = crtk_pkg::IDX_W - LOW_W;

  typedef struct packed {
    logic [crtk_pkg::SCORE_W-1:0] score;
    logic [crtk_pkg::FRAC_W-1:0]  b0;
    logic [crtk_pkg::FRAC_W-1:0]  m0;
    logic [crtk_pkg::FRAC_W-1:0]  b1;
    logic [crtk_pkg::FRAC_W-1:0]  m1;
  } slot_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_INS,
    ST_RD1,
    ST_RD2
  } state_t;

  state_t state;
  crtk_pkg::word_t cur;
  logic [LD-1:0] cvec, used, prev_c, ins_here, shift_in, used_next;
  slot_t slots [LD];
  slot_t new_slot;
  logic  grp_used [N_GRP];
  slot_t grp_slot [N_GRP];
  logic [crtk_pkg::IDX_W-1:0] pos;
  logic [GSEL_W-1:0] gsel;
  logic take, do_ins;
  crtk_pkg::rsp_t ins_rsp, rd_rsp;

  assign take = head_valid && (!rsp_valid || rsp_ready);
  assign pop  = (state == ST_IDLE) && take;

  // cvec is monotone: first set bit is the insert slot
  assign prev_c   = {cvec[LD-2:0], 1'b0};
  assign ins_here = cvec & ~prev_c;
  assign shift_in = cvec & prev_c;
  assign do_ins   = (state == ST_INS) && cur.pass && cvec[LD-1];
  assign gsel     = cur.rank[crtk_pkg::IDX_W-1:LOW_W];

  always_comb begin
    pos = '0;
    for (int j = 0; j < LD; j++) begin
      if (ins_here[j]) begin
        pos = pos | crtk_pkg::IDX_W'(j);
      end
    end
  end

  always_comb begin
    new_slot.score = cur.score;
    new_slot.b0    = cur.b0;
    new_slot.m0    = cur.m0;
    new_slot.b1    = cur.b1;
    new_slot.m1    = cur.m1;

    used_next = (used & ~cvec) | ins_here | (shift_in & {used[LD-2:0], 1'b0});

    ins_rsp             = '0;
    ins_rsp.accepted    = do_ins;
    ins_rsp.insert_rank = do_ins ? crtk_pkg::RANK_W'(pos) : '0;

    rd_rsp = '0;
    if (grp_used[gsel]) begin
      rd_rsp.entry_valid            = 1'b1;
      rd_rsp.entry_beta_first       = grp_slot[gsel].b0;
      rd_rsp.entry_mortality_first  = grp_slot[gsel].m0;
      rd_rsp.entry_beta_second      = grp_slot[gsel].b1;
      rd_rsp.entry_mortality_second = grp_slot[gsel].m1;
      rd_rsp.entry_score            = grp_slot[gsel].score;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (take) begin
            cur   <= head_word;
            state <= (head_word.op == crtk_pkg::OP_READ) ? ST_RD1 : ST_CMP;
          end
        end
        ST_CMP: begin
          for (int j = 0; j < LD; j++) begin
            cvec[j] <= !used[j] || (slots[j].score > cur.score);
          end
          state <= ST_INS;
        end
        ST_INS: begin
          rsp       <= ins_rsp;
          rsp_valid <= 1'b1;
          state     <= ST_IDLE;
        end
        ST_RD1: begin
          for (int g = 0; g < N_GRP; g++) begin
            grp_used[g] <= used[{GSEL_W'(g), cur.rank[LOW_W-1:0]}];
            grp_slot[g] <= slots[{GSEL_W'(g), cur.rank[LOW_W-1:0]}];
          end
          state <= ST_RD2;
        end
        ST_RD2: begin
          rsp       <= rd_rsp;
          rsp_valid <= 1'b1;
          state     <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (do_ins) begin
      used <= used_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_ins) begin
      if (ins_here[0]) begin
        slots[0] <= new_slot;
      end
      for (int j = 1; j < LD; j++) begin
        if (ins_here[j]) begin
          slots[j] <= new_slot;
        end else if (shift_in[j]) begin
          slots[j] <= slots[j-1];
        end
      end
    end
  end

endmodule

### rtl/constrained_residual_top_k.sv
// Constrained residual best-K list, top level.
// The list sequencer steps through take, compare, shift or read and takes a
// new word only once it is back in idle; the front takes one word per cycle
// into a 4-deep queue unless its last stage is held by a full queue.
// Reset: valid, pointer, state and config registers return to their reset values and the list is emptied at
// once by clearing its occupancy bits; no clearing pass. Depends on crtk_pkg.
module constrained_residual_top_k (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  crtk_pkg::req_t                req,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output crtk_pkg::rsp_t                rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [crtk_pkg::CFG_AW-1:0]   paddr,
  input  logic [crtk_pkg::CFG_DW-1:0]   pwdata,
  output logic [crtk_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready
);

  crtk_pkg::cfg_t  cfg;
  crtk_pkg::word_t fw, hw;
  logic fw_valid, q_full, pop, h_valid;
  logic [crtk_pkg::REG_W-1:0] reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[crtk_pkg::CFG_AW-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.n_out0         <= '0;
      cfg.n_out1         <= '0;
      cfg.n_out2         <= '0;
      cfg.lambda_start   <= '0;
      cfg.mw_ratio_recip <= crtk_pkg::RECIP_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        crtk_pkg::REG_N_OUT0:         cfg.n_out0 <= pwdata[crtk_pkg::CNT_W-1:0];
        crtk_pkg::REG_N_OUT1:         cfg.n_out1 <= pwdata[crtk_pkg::CNT_W-1:0];
        crtk_pkg::REG_N_OUT2:         cfg.n_out2 <= pwdata[crtk_pkg::CNT_W-1:0];
        crtk_pkg::REG_LAMBDA_START:   cfg.lambda_start <= pwdata[crtk_pkg::FRAC_W-1:0];
        crtk_pkg::REG_MW_RATIO_RECIP: cfg.mw_ratio_recip <= pwdata[crtk_pkg::RECIP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      crtk_pkg::REG_N_OUT0:         prdata = crtk_pkg::CFG_DW'(cfg.n_out0);
      crtk_pkg::REG_N_OUT1:         prdata = crtk_pkg::CFG_DW'(cfg.n_out1);
      crtk_pkg::REG_N_OUT2:         prdata = crtk_pkg::CFG_DW'(cfg.n_out2);
      crtk_pkg::REG_LAMBDA_START:   prdata = crtk_pkg::CFG_DW'(cfg.lambda_start);
      crtk_pkg::REG_MW_RATIO_RECIP: prdata = crtk_pkg::CFG_DW'(cfg.mw_ratio_recip);
      default:                      prdata = '0;
    endcase
  end

  crtk_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .word_valid (fw_valid),
    .word_full  (q_full),
    .word       (fw)
  );

  crtk_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fw_valid),
    .full       (q_full),
    .push_word  (fw),
    .pop        (pop),
    .head_valid (h_valid),
    .head_word  (hw)
  );

  crtk_list u_list (
    .clk        (clk),
    .rst        (rst),
    .head_valid (h_valid),
    .head_word  (hw),
    .pop        (pop),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp)
  );

endmodule
